FILE: rtl/core/ptpa_pkg.sv
// Shared types and constants of the pointing-to-particle angle block.
// Holds the CORDIC arctangent table, the gain constant and register indexes.
// Depends on nothing; used by every module of the block.
package ptpa_pkg;

    localparam int MAX_STAGES = 24;
    // Root bits of floor(sqrt(2^60 - c^2)), result at most 2^30
    localparam int SQRT_BITS  = 31;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [31:0] t_trig;

    localparam logic [CFG_IDX_W-1:0] REG_TELESCOPE_ZENITH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TELESCOPE_AZIMUTH = 8'd1;

    // CORDIC start vector, 1/K in Q1.30
    localparam t_trig CORDIC_GAIN = 32'sd652032874;
    // Q8.8 degrees per half turn times two: 180 * 256 * 2
    localparam logic [16:0] DEG_SCALE = 17'd92160;

    // atan(2^-i) in angle units, 2^32 per turn
    localparam logic [31:0] ATAN_BAM [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

FILE: rtl/core/ptpa_sincos.sv
// Pipelined rotation-mode CORDIC: sine and cosine of a 32-bit angle.
// One register per iteration plus input and quadrant-fix registers.
// Depends on ptpa_pkg.
module ptpa_sincos #(
    parameter int STAGES = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [31:0]      i_angle,
    output ptpa_pkg::t_trig  o_sin,
    output ptpa_pkg::t_trig  o_cos
);
    import ptpa_pkg::*;

    t_trig              r_x [STAGES+1];
    t_trig              r_y [STAGES+1];
    logic signed [32:0] r_z [STAGES+1];
    logic [1:0]         r_q [STAGES+1];
    t_trig              r_sin;
    t_trig              r_cos;

    // Angle within its quadrant; the quadrant is applied after the iterations
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= {3'b000, i_angle[29:0]};
            r_q[0] <= i_angle[31:30];
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        t_trig dx;
        t_trig dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][32]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - 33'(ATAN_BAM[i]);
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + 33'(ATAN_BAM[i]);
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[STAGES])
                2'd0: begin
                    r_cos <= r_x[STAGES];
                    r_sin <= r_y[STAGES];
                end
                2'd1: begin
                    r_cos <= -r_y[STAGES];
                    r_sin <= r_x[STAGES];
                end
                2'd2: begin
                    r_cos <= -r_x[STAGES];
                    r_sin <= -r_y[STAGES];
                end
                default: begin
                    r_cos <= r_y[STAGES];
                    r_sin <= -r_x[STAGES];
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: rtl/core/ptpa_acos.sv
// Pipelined arccos of a clamped Q1.30 cosine, result in Q8.8 degrees.
// Square, bit-per-stage square root, vectoring CORDIC, clamp and scale.
// Depends on ptpa_pkg.
module ptpa_acos #(
    parameter int STAGES = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  ptpa_pkg::t_trig  i_c,
    output logic [15:0]      o_deg
);
    import ptpa_pkg::*;

    logic [63:0]          r_sq;
    t_trig                r_c1;
    logic [61:0]          r_rem  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0] r_root [SQRT_BITS+1];
    t_trig                r_cv   [SQRT_BITS+1];
    logic signed [33:0]   r_vx   [STAGES+1];
    logic signed [33:0]   r_vy   [STAGES+1];
    logic signed [33:0]   r_vz   [STAGES+1];
    logic [31:0]          r_zc;
    logic [48:0]          r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq      <= 64'(i_c) * 64'(i_c);
            r_c1      <= i_c;
            r_rem[0]  <= (62'(1) << 60) - r_sq[61:0];
            r_root[0] <= '0;
            r_cv[0]   <= r_c1;
        end
    end

    // One root bit per stage, most significant first
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
        localparam int K = SQRT_BITS - 1 - j;
        logic [61:0] trial;
        assign trial = (62'(r_root[j]) << (K + 1)) | (62'(1) << (2 * K));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[j] >= trial) begin
                    r_rem[j+1]  <= r_rem[j] - trial;
                    r_root[j+1] <= r_root[j] | (SQRT_BITS'(1) << K);
                end else begin
                    r_rem[j+1]  <= r_rem[j];
                    r_root[j+1] <= r_root[j];
                end
                r_cv[j+1] <= r_cv[j];
            end
        end
    end

    // Negative cosine: pre-rotate by a quarter turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_cv[SQRT_BITS][31]) begin
                r_vx[0] <= 34'(r_root[SQRT_BITS]);
                r_vy[0] <= -34'(r_cv[SQRT_BITS]);
                r_vz[0] <= 34'sd1073741824;
            end else begin
                r_vx[0] <= 34'(r_cv[SQRT_BITS]);
                r_vy[0] <= 34'(r_root[SQRT_BITS]);
                r_vz[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_vec
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        assign dx = r_vy[i] >>> i;
        assign dy = r_vx[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_vy[i][33]) begin
                    r_vx[i+1] <= r_vx[i] - dx;
                    r_vy[i+1] <= r_vy[i] + dy;
                    r_vz[i+1] <= r_vz[i] - 34'(ATAN_BAM[i]);
                end else begin
                    r_vx[i+1] <= r_vx[i] + dx;
                    r_vy[i+1] <= r_vy[i] - dy;
                    r_vz[i+1] <= r_vz[i] + 34'(ATAN_BAM[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_vz[STAGES][33]) begin
                r_zc <= '0;
            end else if (r_vz[STAGES] > 34'sd2147483648) begin
                r_zc <= 32'h8000_0000;
            end else begin
                r_zc <= r_vz[STAGES][31:0];
            end
            r_prod <= 49'(r_zc) * 49'(DEG_SCALE) + (49'(1) << 31);
        end
    end

    assign o_deg = r_prod[47:32];

endmodule

FILE: rtl/core/pointing_to_particle_angle.sv
// Top level: angle between the telescope axis and a particle direction.
// Instantiates ptpa_sincos (three times) and ptpa_acos; uses ptpa_pkg.
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_ready       i_particle_zenith, i_particle_azimuth
//  output    out        o_valid / i_ready       o_separation_degrees
//  config    in         i_cfg_we (no wait)      i_cfg_index, i_cfg_wdata
//
// Pipeline depth is set by the two CORDIC pipelines and the 31-stage square root;
// one item is taken every cycle unless a waiting result stalls the pipeline.
// Reset clears the valid bits and the telescope registers only.
// A result waiting at the output stalls the whole pipeline in place; bubbles are
// filled while the output register is empty or being taken.
module pointing_to_particle_angle #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [15:0]                       i_particle_zenith,
    input  logic [15:0]                       i_particle_azimuth,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [15:0]                       o_separation_degrees,
    input  logic                              i_cfg_we,
    input  logic [ptpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptpa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import ptpa_pkg::*;

    localparam int          LAT   = 2 * CORDIC_STAGES + 41;
    localparam int          C_IDX = CORDIC_STAGES + 4;
    localparam int          SH    = 32 - ANGLE_BITS;
    localparam logic [31:0] AMASK = 32'((64'(1) << ANGLE_BITS) - 64'(1));

    function automatic logic [31:0] to_bam(input logic [15:0] v);
        return (32'(v) & AMASK) << SH;
    endfunction

    logic [15:0]    r_tel_zenith;
    logic [15:0]    r_tel_azimuth;
    logic [LAT-1:0] r_vld;
    logic           en;
    logic [31:0]    diff_ang;
    t_trig          s_tz, c_tz, s_pz, c_pz, s_d, c_d;
    logic [63:0]    ss_full, cc_full, p_full;
    t_trig          r_ss, r_cc, r_cd, r_p, r_cc2, r_c;
    logic signed [32:0] c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tel_zenith  <= '0;
            r_tel_azimuth <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TELESCOPE_ZENITH:  r_tel_zenith  <= i_cfg_wdata;
                REG_TELESCOPE_AZIMUTH: r_tel_azimuth <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign diff_ang = to_bam(r_tel_azimuth) - to_bam(i_particle_azimuth);

    ptpa_sincos #(.STAGES(CORDIC_STAGES)) u_tz (
        .i_clk(i_clk), .i_en(en), .i_angle(to_bam(r_tel_zenith)),
        .o_sin(s_tz), .o_cos(c_tz)
    );
    ptpa_sincos #(.STAGES(CORDIC_STAGES)) u_pz (
        .i_clk(i_clk), .i_en(en), .i_angle(to_bam(i_particle_zenith)),
        .o_sin(s_pz), .o_cos(c_pz)
    );
    ptpa_sincos #(.STAGES(CORDIC_STAGES)) u_d (
        .i_clk(i_clk), .i_en(en), .i_angle(diff_ang),
        .o_sin(s_d), .o_cos(c_d)
    );

    assign ss_full = 64'(s_tz) * 64'(s_pz);
    assign cc_full = 64'(c_tz) * 64'(c_pz);
    assign p_full  = 64'(r_ss) * 64'(r_cd);
    assign c_sum   = 33'(r_p) + 33'(r_cc2);

    // Products back to Q1.30 by floor shift; clamp the cosine to [-1, 1]
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ss  <= ss_full[61:30];
            r_cc  <= cc_full[61:30];
            r_cd  <= c_d;
            r_p   <= p_full[61:30];
            r_cc2 <= r_cc;
            if (c_sum > 33'sd1073741824) begin
                r_c <= 32'sd1073741824;
            end else if (c_sum < -33'sd1073741824) begin
                r_c <= -32'sd1073741824;
            end else begin
                r_c <= c_sum[31:0];
            end
        end
    end

    ptpa_acos #(.STAGES(CORDIC_STAGES)) u_acos (
        .i_clk(i_clk), .i_en(en), .i_c(r_c), .o_deg(o_separation_degrees)
    );

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_separation_degrees <= 16'd46080)
        else $error("separation above 180 degrees");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld) && $stable(o_separation_degrees))
        else $error("pipeline moved during stall");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[C_IDX] |-> (r_c <= 32'sd1073741824) && (r_c >= -32'sd1073741824))
        else $error("cosine outside clamp range");

endmodule

FILE: test/pointing_to_particle_angle_checker.sv
// Checker for pointing_to_particle_angle: watches the input and output channels,
// predicts each separation from the telescope registers and compares in order.
// Depends on ptpa_pkg for the CORDIC table, gain and register indexes.
`timescale 1ns / 1ps
module pointing_to_particle_angle_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_particle_zenith,
    input  logic [15:0] i_particle_azimuth,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [15:0] i_separation_degrees,
    input  logic        i_cfg_we,
    input  logic [ptpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ptpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);
    import ptpa_pkg::*;

    localparam int STAGES = 16;
    localparam longint ONE_Q30 = 64'sd1 << 30;

    logic [15:0] axis_zenith;
    logic [15:0] axis_azimuth;
    logic [15:0] separation_queue [$];

    assign o_pending = separation_queue.size();

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void rotate_sincos(input logic [31:0] a, output longint s,
                                          output longint c);
        longint x, y, z, dx, dy;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_BAM[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_BAM[i]);
            end
        end
        case (a[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint root_floor(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] arccos_q88(longint c);
        longint s, x, y, z, dx, dy;
        logic [63:0] zu;
        z = 0;
        if (c > ONE_Q30) c = ONE_Q30;
        if (c < -ONE_Q30) c = -ONE_Q30;
        s = root_floor(ONE_Q30 * ONE_Q30 - c * c);
        x = c; y = s;
        if (c < 0) begin
            x = s; y = -c; z = ONE_Q30;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y < 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_BAM[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_BAM[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 << 31)) z = 64'sd1 << 31;
        zu = z;
        zu = (zu * 64'd92160 + (64'd1 << 31)) >> 32;
        return zu[15:0];
    endfunction

    function automatic logic [15:0] predict_separation(logic [15:0] pz, logic [15:0] pa);
        longint stz, ctz, spz, cpz, sd, cd, ss, c;
        logic [31:0] d;
        d = {axis_azimuth, 16'h0} - {pa, 16'h0};
        rotate_sincos({axis_zenith, 16'h0}, stz, ctz);
        rotate_sincos({pz, 16'h0}, spz, cpz);
        rotate_sincos(d, sd, cd);
        ss = floor_shift(stz * spz, 30);
        c = floor_shift(ss * cd, 30) + floor_shift(ctz * cpz, 30);
        return arccos_q88(c);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            axis_zenith  <= '0;
            axis_azimuth <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TELESCOPE_ZENITH) axis_zenith <= i_cfg_wdata;
                else if (i_cfg_index == REG_TELESCOPE_AZIMUTH) axis_azimuth <= i_cfg_wdata;
            end
            if (i_valid && i_in_ready)
                separation_queue.push_back(
                    predict_separation(i_particle_zenith, i_particle_azimuth));
            if (i_out_valid && i_ready) begin
                if (separation_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", i_separation_degrees));
                end else begin
                    if (separation_queue[0] !== i_separation_degrees)
                        report_mismatch($sformatf("separation got %0d want %0d",
                            i_separation_degrees, separation_queue[0]));
                    void'(separation_queue.pop_front());
                end
            end
        end
    end
endmodule

FILE: test/pointing_to_particle_angle_tb.sv
// Testbench top for pointing_to_particle_angle: drives directions in bursts,
// stalls the output, sweeps telescope settings; checker does the comparing.
// Depends on ptpa_pkg and pointing_to_particle_angle_checker.
`timescale 1ns / 1ps
module pointing_to_particle_angle_tb;
    import ptpa_pkg::*;

    localparam int LATENCY = 2 * 16 + 41;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic [15:0] i_particle_zenith = 0;
    logic [15:0] i_particle_azimuth = 0;
    logic o_valid;
    logic i_ready = 0;
    logic [15:0] o_separation_degrees;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = 0;
    int errors, pending, cycles;
    int stall_mode;

    always #1 i_clk = ~i_clk;

    pointing_to_particle_angle uut (.*);

    pointing_to_particle_angle_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_particle_zenith,
        .i_particle_azimuth, .i_out_valid(o_valid), .i_ready, .i_separation_degrees(o_separation_degrees),
        .i_cfg_we, .i_cfg_index, .i_cfg_wdata, .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pointing_to_particle_angle_tb: errors");
            $finish;
        end
    end

    // receiver: mode 0 never stalls, 1 light, 2 heavy, 3 periodic
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 7) != 0);
            2: i_ready <= ($urandom_range(0, 2) == 0);
            default: i_ready <= (cycles % 5 < 3);
        endcase
    end

    initial stall_mode = 0;
    initial cycles = 0;

    task automatic send_direction(input logic [15:0] pz, input logic [15:0] pa);
        i_valid <= 1'b1;
        i_particle_zenith <= pz;
        i_particle_azimuth <= pa;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic write_axis(input logic [15:0] tz, input logic [15:0] ta);
        i_valid <= 1'b0;
        // let the last item reach the checker before polling its queue
        repeat (LATENCY + 4) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_TELESCOPE_ZENITH;
        i_cfg_wdata <= tz;
        @(posedge i_clk);
        i_cfg_index <= REG_TELESCOPE_AZIMUTH;
        i_cfg_wdata <= ta;
        @(posedge i_clk);
        // out-of-range index is ignored
        i_cfg_index <= 8'd7;
        i_cfg_wdata <= 16'hFFFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_zenith();
        case ($urandom_range(0, 9))
            0: return 16'h0;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    initial begin
        logic [15:0] dir_pz [] = '{16'h0, 16'h8000, 16'h4000, 16'hFFFF, 16'h0001, 16'hC000,
                                    16'h2000, 16'h4000, 16'h7FFF, 16'h8001};
        logic [15:0] dir_pa [] = '{16'h0, 16'h0, 16'h8000, 16'hFFFF, 16'h0001, 16'h4000,
                                    16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
        logic [15:0] axis_tz [] = '{16'h0, 16'h8000, 16'h4000, 16'h1234, 16'hFFFF, 16'h2AAA};
        logic [15:0] axis_ta [] = '{16'h0, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF, 16'hC3C3};
        int burst;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: reset axis, then extremes under the first two axis settings
        for (int k = 0; k < dir_pz.size(); k++) send_direction(dir_pz[k], dir_pa[k]);
        for (int p = 0; p < axis_tz.size(); p++) begin
            stall_mode = p % 4;
            write_axis(axis_tz[p], axis_ta[p]);
            if (p < 2)
                for (int k = 0; k < 6; k++) send_direction(dir_pz[k], dir_pa[k]);
            for (int n = 0; n < 300; n += burst) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst; b++) begin
                    send_direction(random_zenith(),
                        ($urandom_range(0, 7) == 0) ? axis_ta[p] : 16'($urandom));
                end
                if ($urandom_range(0, 2) != 0) pause_sender();
            end
        end
        i_valid <= 1'b0;
        repeat (LATENCY + 10) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        if (errors == 0)
            $display("pointing_to_particle_angle_tb: clean");
        else
            $display("pointing_to_particle_angle_tb: errors");
        $finish;
    end
endmodule
